[design/pgnlex_pkg.sv]
`default_nettype none

package pgnlex_pkg;

    typedef struct packed {
        logic [15:0] char_code;
        logic        line_last;
    } char_beat_t;

    typedef struct packed {
        logic [11:0] span_start;
        logic [12:0] span_length;
        logic [2:0]  span_class;
        logic        last_result;
    } span_beat_t;

    typedef enum logic [3:0] {
        CC_OTHER,
        CC_DIGIT,
        CC_LETTER,
        CC_LBRACK,
        CC_RBRACK,
        CC_LBRACE,
        CC_RBRACE,
        CC_CMT,
        CC_PUNCT,
        CC_MINUS,
        CC_PLUS,
        CC_HASH,
        CC_UNDER,
        CC_BSLASH,
        CC_QUOTE,
        CC_EOL
    } char_class_t;

    typedef enum logic [2:0] {
        CL_NONE    = 3'd0,
        CL_PUNCT   = 3'd1,
        CL_STRING  = 3'd2,
        CL_NUMBER  = 3'd3,
        CL_COMMENT = 3'd4,
        CL_MOVE    = 3'd5,
        CL_IDENT   = 3'd6
    } span_class_t;

    typedef struct packed {
        char_class_t cls;
        logic        line_last;
    } char_rec_t;

endpackage

`default_nettype wire

[design/pgnlex_front.sv]
`default_nettype none

module pgnlex_front #(
    parameter int MAX_LINE = 4096
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   char_valid,
    output logic                        char_stall,
    input  wire pgnlex_pkg::char_beat_t char_beat,
    input  wire logic                   q_full,
    output logic                        push,
    output pgnlex_pkg::char_rec_t       rec,
    output logic [$clog2(MAX_LINE+1)-1:0] pos
);

    localparam int POS_W = $clog2(MAX_LINE + 1);

    localparam logic [15:0] CH_0      = 16'h0030;
    localparam logic [15:0] CH_9      = 16'h0039;
    localparam logic [15:0] CH_UA     = 16'h0041;
    localparam logic [15:0] CH_UZ     = 16'h005A;
    localparam logic [15:0] CH_LA     = 16'h0061;
    localparam logic [15:0] CH_LZ     = 16'h007A;
    localparam logic [15:0] CH_LBRACK = 16'h005B;
    localparam logic [15:0] CH_RBRACK = 16'h005D;
    localparam logic [15:0] CH_LBRACE = 16'h007B;
    localparam logic [15:0] CH_RBRACE = 16'h007D;
    localparam logic [15:0] CH_SEMI   = 16'h003B;
    localparam logic [15:0] CH_PCT    = 16'h0025;
    localparam logic [15:0] CH_DOLLAR = 16'h0024;
    localparam logic [15:0] CH_DOT    = 16'h002E;
    localparam logic [15:0] CH_LPAREN = 16'h0028;
    localparam logic [15:0] CH_RPAREN = 16'h0029;
    localparam logic [15:0] CH_BANG   = 16'h0021;
    localparam logic [15:0] CH_QMARK  = 16'h003F;
    localparam logic [15:0] CH_SLASH  = 16'h002F;
    localparam logic [15:0] CH_STAR   = 16'h002A;
    localparam logic [15:0] CH_MINUS  = 16'h002D;
    localparam logic [15:0] CH_PLUS   = 16'h002B;
    localparam logic [15:0] CH_HASH   = 16'h0023;
    localparam logic [15:0] CH_UNDER  = 16'h005F;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_QUOTE  = 16'h0022;
    localparam logic [15:0] CH_CR     = 16'h000D;
    localparam logic [15:0] CH_LF     = 16'h000A;

    logic [POS_W-1:0]        char_position_reg;
    logic [POS_W-1:0]        char_position_next;
    pgnlex_pkg::char_class_t cls;

    always_comb
    begin
        if (char_beat.char_code inside {[CH_0:CH_9]})
        begin
            cls = pgnlex_pkg::CC_DIGIT;
        end
        else if (char_beat.char_code inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]})
        begin
            cls = pgnlex_pkg::CC_LETTER;
        end
        else if (char_beat.char_code inside {CH_DOLLAR, CH_DOT, CH_LPAREN, CH_RPAREN,
                                             CH_BANG, CH_QMARK, CH_SLASH, CH_STAR})
        begin
            cls = pgnlex_pkg::CC_PUNCT;
        end
        else if (char_beat.char_code inside {CH_SEMI, CH_PCT})
        begin
            cls = pgnlex_pkg::CC_CMT;
        end
        else if (char_beat.char_code inside {CH_CR, CH_LF})
        begin
            cls = pgnlex_pkg::CC_EOL;
        end
        else
        begin
            case (char_beat.char_code)
                CH_LBRACK: cls = pgnlex_pkg::CC_LBRACK;
                CH_RBRACK: cls = pgnlex_pkg::CC_RBRACK;
                CH_LBRACE: cls = pgnlex_pkg::CC_LBRACE;
                CH_RBRACE: cls = pgnlex_pkg::CC_RBRACE;
                CH_MINUS:  cls = pgnlex_pkg::CC_MINUS;
                CH_PLUS:   cls = pgnlex_pkg::CC_PLUS;
                CH_HASH:   cls = pgnlex_pkg::CC_HASH;
                CH_UNDER:  cls = pgnlex_pkg::CC_UNDER;
                CH_BSLASH: cls = pgnlex_pkg::CC_BSLASH;
                CH_QUOTE:  cls = pgnlex_pkg::CC_QUOTE;
                default:   cls = pgnlex_pkg::CC_OTHER;
            endcase
        end
    end

    // saturate at the last position of a long line
    always_comb
    begin
        if (char_position_reg < POS_W'(MAX_LINE))
        begin
            pos = char_position_reg;
        end
        else
        begin
            pos = POS_W'(MAX_LINE - 1);
        end
        char_position_next = char_beat.line_last ? '0 : pos + POS_W'(1);
    end

    assign char_stall    = q_full;
    assign push          = char_valid && !q_full;
    assign rec.cls       = cls;
    assign rec.line_last = char_beat.line_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_position_reg <= '0;
        end
        else if (push)
        begin
            char_position_reg <= char_position_next;
        end
    end

endmodule

`default_nettype wire

[design/pgnlex_fifo.sv]
`default_nettype none

module pgnlex_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[design/pgnlex_back.sv]
`default_nettype none

module pgnlex_back #(
    parameter int MAX_LINE = 4096
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       head_valid,
    input  wire pgnlex_pkg::char_rec_t      head_rec,
    input  wire logic [$clog2(MAX_LINE+1)-1:0] head_pos,
    output logic                            pop,
    output logic                            span_valid,
    input  wire logic                       span_stall,
    output pgnlex_pkg::span_beat_t          span_beat
);

    localparam int POS_W  = $clog2(MAX_LINE + 1);
    localparam int SLOTS  = 5;

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [3:0] {
        ST_NORMAL,
        ST_TAG,
        ST_STRING,
        ST_STR_ESC,
        ST_LINE_CMT,
        ST_BRACE_CMT,
        ST_MOVE,
        ST_NUMBER,
        ST_IDENT
    } lex_state_t;

    typedef struct packed {
        lex_state_t              st;
        pos_t                    start;
        logic                    again;
        logic                    e1_v;
        pos_t                    e1_s;
        pos_t                    e1_e;
        pgnlex_pkg::span_class_t e1_cls;
        logic                    e2_v;
    } step_t;

    function automatic step_t lex_step(lex_state_t st, pos_t start,
                                       pgnlex_pkg::char_class_t cc, pos_t p);
        step_t r;
        pos_t  p1;
        p1       = p + pos_t'(1);
        r.st     = st;
        r.start  = start;
        r.again  = 1'b0;
        r.e1_v   = 1'b0;
        r.e1_s   = start;
        r.e1_e   = p1;
        r.e1_cls = pgnlex_pkg::CL_NONE;
        r.e2_v   = 1'b0;
        case (st)
            ST_STRING:
            begin
                if (cc == pgnlex_pkg::CC_BSLASH)
                begin
                    r.st = ST_STR_ESC;
                end
                else if (cc == pgnlex_pkg::CC_QUOTE)
                begin
                    r.e1_v   = 1'b1;
                    r.e1_cls = pgnlex_pkg::CL_STRING;
                    r.start  = p1;
                    r.st     = ST_TAG;
                end
            end
            ST_STR_ESC:
            begin
                r.st = ST_STRING;
            end
            ST_LINE_CMT:
            begin
                if (cc == pgnlex_pkg::CC_EOL)
                begin
                    r.e1_v   = 1'b1;
                    r.e1_cls = pgnlex_pkg::CL_COMMENT;
                    r.start  = p1;
                    r.st     = ST_NORMAL;
                end
            end
            ST_BRACE_CMT:
            begin
                if (cc == pgnlex_pkg::CC_RBRACE)
                begin
                    r.e1_v   = 1'b1;
                    r.e1_cls = pgnlex_pkg::CL_COMMENT;
                    r.start  = p1;
                    r.st     = ST_NORMAL;
                end
            end
            ST_IDENT:
            begin
                if (!(cc inside {pgnlex_pkg::CC_DIGIT, pgnlex_pkg::CC_LETTER,
                                 pgnlex_pkg::CC_UNDER}))
                begin
                    r.e1_v   = 1'b1;
                    r.e1_e   = p;
                    r.e1_cls = pgnlex_pkg::CL_IDENT;
                    r.start  = p;
                    r.st     = ST_TAG;
                    r.again  = 1'b1;
                end
            end
            ST_MOVE:
            begin
                if (!(cc inside {pgnlex_pkg::CC_DIGIT, pgnlex_pkg::CC_LETTER,
                                 pgnlex_pkg::CC_PLUS, pgnlex_pkg::CC_MINUS,
                                 pgnlex_pkg::CC_HASH}))
                begin
                    r.e1_v   = 1'b1;
                    r.e1_e   = p;
                    r.e1_cls = pgnlex_pkg::CL_MOVE;
                    r.start  = p;
                    r.st     = ST_NORMAL;
                    r.again  = 1'b1;
                end
            end
            ST_NUMBER:
            begin
                if (cc != pgnlex_pkg::CC_DIGIT)
                begin
                    r.e1_v   = 1'b1;
                    r.e1_e   = p;
                    r.e1_cls = pgnlex_pkg::CL_NUMBER;
                    r.start  = p;
                    r.st     = ST_NORMAL;
                    r.again  = 1'b1;
                end
            end
            ST_TAG:
            begin
                if (cc == pgnlex_pkg::CC_QUOTE)
                begin
                    r.start = p;
                    r.st    = ST_STRING;
                end
                else if (cc == pgnlex_pkg::CC_RBRACK)
                begin
                    r.e1_v   = 1'b1;
                    r.e1_e   = p;
                    r.e1_cls = pgnlex_pkg::CL_NONE;
                    r.e2_v   = 1'b1;
                    r.start  = p1;
                    r.st     = ST_NORMAL;
                end
                else if (cc inside {pgnlex_pkg::CC_UNDER, pgnlex_pkg::CC_LETTER})
                begin
                    r.start = p;
                    r.st    = ST_IDENT;
                end
            end
            default:
            begin
                r.st   = ST_NORMAL;
                r.e1_s = p;
                case (cc)
                    pgnlex_pkg::CC_LBRACK:
                    begin
                        r.e1_v   = 1'b1;
                        r.e1_cls = pgnlex_pkg::CL_PUNCT;
                        r.start  = p1;
                        r.st     = ST_TAG;
                    end
                    pgnlex_pkg::CC_PUNCT, pgnlex_pkg::CC_RBRACK, pgnlex_pkg::CC_MINUS:
                    begin
                        r.e1_v   = 1'b1;
                        r.e1_cls = pgnlex_pkg::CL_PUNCT;
                        r.start  = p1;
                    end
                    pgnlex_pkg::CC_DIGIT:
                    begin
                        r.start = p;
                        r.st    = ST_NUMBER;
                    end
                    pgnlex_pkg::CC_LBRACE:
                    begin
                        r.start = p;
                        r.st    = ST_BRACE_CMT;
                    end
                    pgnlex_pkg::CC_CMT:
                    begin
                        r.start = p;
                        r.st    = ST_LINE_CMT;
                    end
                    pgnlex_pkg::CC_LETTER:
                    begin
                        r.start = p;
                        r.st    = ST_MOVE;
                    end
                    default:
                    begin
                    end
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic pgnlex_pkg::span_class_t state_class(lex_state_t st);
        pgnlex_pkg::span_class_t c;
        case (st)
            ST_STRING, ST_STR_ESC:     c = pgnlex_pkg::CL_STRING;
            ST_LINE_CMT, ST_BRACE_CMT: c = pgnlex_pkg::CL_COMMENT;
            ST_MOVE:                   c = pgnlex_pkg::CL_MOVE;
            ST_NUMBER:                 c = pgnlex_pkg::CL_NUMBER;
            ST_IDENT:                  c = pgnlex_pkg::CL_IDENT;
            default:                   c = pgnlex_pkg::CL_NONE;
        endcase
        return c;
    endfunction

    lex_state_t             lex_state_reg;
    lex_state_t             lex_state_next;
    pos_t                   start_reg;
    pos_t                   start_next;
    logic [SLOTS-1:0]       done_reg;
    logic [SLOTS-1:0]       done_next;
    logic                   span_valid_reg;
    logic                   span_valid_next;
    pgnlex_pkg::span_beat_t span_beat_reg;
    pgnlex_pkg::span_beat_t span_beat_next;

    step_t                   r1;
    step_t                   r2;
    pos_t                    p1;
    pos_t                    slot_s   [SLOTS];
    pos_t                    slot_e   [SLOTS];
    pgnlex_pkg::span_class_t slot_cls [SLOTS];
    logic [SLOTS-1:0]        slot_flag;
    logic [SLOTS-1:0]        slot_valid;
    logic [SLOTS-1:0]        pending;
    logic [SLOTS-1:0]        sel_oh;
    logic [SLOTS-1:0]        rest;
    pos_t                    sel_s;
    pos_t                    sel_e;
    pgnlex_pkg::span_class_t sel_cls;
    logic                    out_free;
    logic                    emit;

    // one beat may close up to two tokens per pass plus the line flush
    always_comb
    begin
        p1 = head_pos + pos_t'(1);
        r1 = lex_step(lex_state_reg, start_reg, head_rec.cls, head_pos);
        r2 = r1;
        r2.e1_v = 1'b0;
        r2.e2_v = 1'b0;
        if (r1.again)
        begin
            r2 = lex_step(r1.st, r1.start, head_rec.cls, head_pos);
        end

        slot_flag[0] = r1.e1_v;
        slot_s[0]    = r1.e1_s;
        slot_e[0]    = r1.e1_e;
        slot_cls[0]  = r1.e1_cls;
        slot_flag[1] = r1.e2_v;
        slot_s[1]    = head_pos;
        slot_e[1]    = p1;
        slot_cls[1]  = pgnlex_pkg::CL_PUNCT;
        slot_flag[2] = r2.e1_v;
        slot_s[2]    = r2.e1_s;
        slot_e[2]    = r2.e1_e;
        slot_cls[2]  = r2.e1_cls;
        slot_flag[3] = r2.e2_v;
        slot_s[3]    = head_pos;
        slot_e[3]    = p1;
        slot_cls[3]  = pgnlex_pkg::CL_PUNCT;
        slot_flag[4] = head_rec.line_last;
        slot_s[4]    = r2.start;
        slot_e[4]    = p1;
        slot_cls[4]  = state_class(r2.st);

        for (int i = 0; i < SLOTS; i++)
        begin
            slot_valid[i] = slot_flag[i] && (slot_e[i] > slot_s[i]);
        end

        pending = slot_valid & ~done_reg;
        sel_oh  = pending & (~pending + SLOTS'(1));
        rest    = pending & ~sel_oh;

        sel_s   = '0;
        sel_e   = '0;
        sel_cls = pgnlex_pkg::CL_NONE;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (sel_oh[i])
            begin
                sel_s   = slot_s[i];
                sel_e   = slot_e[i];
                sel_cls = slot_cls[i];
            end
        end

        out_free = !span_valid_reg || !span_stall;
        emit     = head_valid && (pending != '0) && out_free;
        pop      = head_valid && (rest == '0) && ((pending == '0) || out_free);

        span_valid_next = emit || (span_valid_reg && !out_free);
        span_beat_next  = span_beat_reg;
        if (emit)
        begin
            span_beat_next.span_start  = 12'(sel_s);
            span_beat_next.span_length = 13'(pos_t'(sel_e - sel_s));
            span_beat_next.span_class  = sel_cls;
            span_beat_next.last_result = (rest == '0);
        end

        lex_state_next = lex_state_reg;
        start_next     = start_reg;
        done_next      = done_reg;
        if (pop)
        begin
            lex_state_next = r2.st;
            start_next     = head_rec.line_last ? '0 : r2.start;
            done_next      = '0;
        end
        else if (emit)
        begin
            done_next = done_reg | sel_oh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_state_reg  <= ST_NORMAL;
            start_reg      <= '0;
            done_reg       <= '0;
            span_valid_reg <= 1'b0;
            span_beat_reg  <= '0;
        end
        else
        begin
            lex_state_reg  <= lex_state_next;
            start_reg      <= start_next;
            done_reg       <= done_next;
            span_valid_reg <= span_valid_next;
            span_beat_reg  <= span_beat_next;
        end
    end

    assign span_valid = span_valid_reg;
    assign span_beat  = span_beat_reg;

endmodule

`default_nettype wire

[design/pgn_token_span_lexer.sv]
// A span beat passes through the character queue and then the output register;
// queued characters and output stalls delay it further.
// Throughput: one character per cycle while the queue has room; a character that closes
// several spans holds the span stage until all are sent; a 4-entry character queue absorbs them.
// Reset (rst_n low, asynchronous): lexer back to normal state, position and span
// start zero, queue and output register empty.
`default_nettype none

module pgn_token_span_lexer #(
    parameter int MAX_LINE = 4096
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   char_valid,
    output logic                        char_stall,
    input  wire pgnlex_pkg::char_beat_t char_beat,
    output logic                        span_valid,
    input  wire logic                   span_stall,
    output pgnlex_pkg::span_beat_t      span_beat
);

    localparam int POS_W   = $clog2(MAX_LINE + 1);
    localparam int REC_W   = $bits(pgnlex_pkg::char_rec_t);
    localparam int Q_W     = REC_W + POS_W;
    localparam int Q_DEPTH = 4;

    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    logic [Q_W-1:0]        q_wdata;
    logic [Q_W-1:0]        q_rdata;
    pgnlex_pkg::char_rec_t front_rec;
    logic [POS_W-1:0]      front_pos;
    pgnlex_pkg::char_rec_t head_rec;
    logic [POS_W-1:0]      head_pos;

    pgnlex_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat),
        .q_full     (q_full),
        .push       (q_push),
        .rec        (front_rec),
        .pos        (front_pos)
    );

    assign q_wdata = {front_rec, front_pos};

    pgnlex_fifo #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign head_rec = pgnlex_pkg::char_rec_t'(q_rdata[Q_W-1:POS_W]);
    assign head_pos = q_rdata[POS_W-1:0];

    pgnlex_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!q_empty),
        .head_rec   (head_rec),
        .head_pos   (head_pos),
        .pop        (q_pop),
        .span_valid (span_valid),
        .span_stall (span_stall),
        .span_beat  (span_beat)
    );

`ifndef NO_ASSERTIONS
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_no_empty_span: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid |-> (span_beat.span_length != 13'd0))
        else $error("zero-length span emitted");

    a_span_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid |-> ((MAX_LINE > 4096) ||
            ((14'(span_beat.span_start) + 14'(span_beat.span_length)) <= 14'(MAX_LINE))))
        else $error("span runs past end of line");
`endif

endmodule

`default_nettype wire

[tb/sv/pgn_token_span_lexer_tb.sv]
`timescale 1ns / 1ps

module pgn_token_span_lexer_tb;

    localparam int MAX_LINE = 4096;

    localparam logic [15:0] CH_SPACE   = 16'h0020;
    localparam logic [15:0] CH_CR      = 16'h000D;
    localparam logic [15:0] CH_LF      = 16'h000A;
    localparam logic [15:0] CH_LBRACK  = 16'h005B;
    localparam logic [15:0] CH_RBRACK  = 16'h005D;
    localparam logic [15:0] CH_LBRACE  = 16'h007B;
    localparam logic [15:0] CH_RBRACE  = 16'h007D;
    localparam logic [15:0] CH_SEMI    = 16'h003B;
    localparam logic [15:0] CH_PERCENT = 16'h0025;
    localparam logic [15:0] CH_DOLLAR  = 16'h0024;
    localparam logic [15:0] CH_HASH    = 16'h0023;
    localparam logic [15:0] CH_UNDER   = 16'h005F;
    localparam logic [15:0] CH_BSLASH  = 16'h005C;
    localparam logic [15:0] CH_QUOTE   = 16'h0022;
    localparam logic [15:0] CH_DOT     = 16'h002E;
    localparam logic [15:0] CH_LPAREN  = 16'h0028;
    localparam logic [15:0] CH_RPAREN  = 16'h0029;
    localparam logic [15:0] CH_BANG    = 16'h0021;
    localparam logic [15:0] CH_QMARK   = 16'h003F;
    localparam logic [15:0] CH_MINUS   = 16'h002D;
    localparam logic [15:0] CH_PLUS    = 16'h002B;
    localparam logic [15:0] CH_SLASH   = 16'h002F;
    localparam logic [15:0] CH_STAR    = 16'h002A;
    localparam logic [15:0] CH_ZERO    = 16'h0030;
    localparam logic [15:0] CH_NINE    = 16'h0039;
    localparam logic [15:0] CH_LA      = 16'h0061;
    localparam logic [15:0] CH_LZ      = 16'h007A;
    localparam logic [15:0] CH_UA      = 16'h0041;
    localparam logic [15:0] CH_UZ      = 16'h005A;

    typedef enum logic [3:0] {
        LX_NORMAL,
        LX_TAG,
        LX_STRING,
        LX_STR_ESC,
        LX_LINE_CMT,
        LX_BRACE_CMT,
        LX_MOVE,
        LX_NUMBER,
        LX_IDENT
    } lex_state_t;

    logic                   clk;
    logic                   rst_n;
    logic                   char_valid = 1'b0;
    logic                   char_stall;
    pgnlex_pkg::char_beat_t char_beat = '0;
    logic                   span_valid;
    logic                   span_stall = 1'b0;
    pgnlex_pkg::span_beat_t span_beat;

    pgn_token_span_lexer #(
        .MAX_LINE(MAX_LINE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .char_valid(char_valid),
        .char_stall(char_stall),
        .char_beat(char_beat),
        .span_valid(span_valid),
        .span_stall(span_stall),
        .span_beat(span_beat)
    );

    // lexer mirror
    lex_state_t             lx_state = LX_NORMAL;
    int                     open_start = 0;
    int                     next_pos = 0;
    pgnlex_pkg::span_beat_t step_spans [4];
    int                     step_n;

    pgnlex_pkg::span_beat_t pending_spans [$];
    pgnlex_pkg::char_beat_t char_q [$];
    logic [15:0]            line_buf [$];

    int errors = 0;
    int sent = 0;
    int run_left = 0;
    int gap_left = 0;
    int gap_max = 4;
    int stall_left = 0;
    int stall_pct = 30;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit is_digit(input logic [15:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_letter(input logic [15:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    task automatic add_span(input int s, input int e, input pgnlex_pkg::span_class_t cls);
        if (e > s && step_n < 4)
        begin
            step_spans[step_n].span_start  = s[11:0];
            step_spans[step_n].span_length = 13'(e - s);
            step_spans[step_n].span_class  = cls;
            step_spans[step_n].last_result = 1'b0;
            step_n++;
        end
    endtask

    task automatic lex_char(input pgnlex_pkg::char_beat_t b);
        logic [15:0]             c;
        lex_state_t              st;
        pgnlex_pkg::span_class_t fcls;
        int                      p;
        int                      s;
        bit                      again;
        c = b.char_code;
        p = (next_pos < MAX_LINE) ? next_pos : MAX_LINE - 1;
        st = lx_state;
        s = open_start;
        step_n = 0;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (st)
                LX_STRING:
                begin
                    if (c == CH_BSLASH)
                        st = LX_STR_ESC;
                    else if (c == CH_QUOTE)
                    begin
                        add_span(s, p + 1, pgnlex_pkg::CL_STRING);
                        s = p + 1;
                        st = LX_TAG;
                    end
                end
                LX_STR_ESC:
                    st = LX_STRING;
                LX_LINE_CMT:
                begin
                    if (c == CH_CR || c == CH_LF)
                    begin
                        add_span(s, p + 1, pgnlex_pkg::CL_COMMENT);
                        s = p + 1;
                        st = LX_NORMAL;
                    end
                end
                LX_BRACE_CMT:
                begin
                    if (c == CH_RBRACE)
                    begin
                        add_span(s, p + 1, pgnlex_pkg::CL_COMMENT);
                        s = p + 1;
                        st = LX_NORMAL;
                    end
                end
                LX_IDENT:
                begin
                    if (!(is_digit(c) || is_letter(c) || c == CH_UNDER))
                    begin
                        add_span(s, p, pgnlex_pkg::CL_IDENT);
                        s = p;
                        st = LX_TAG;
                        again = 1'b1;
                    end
                end
                LX_MOVE:
                begin
                    if (!(is_digit(c) || is_letter(c) || c == CH_PLUS || c == CH_MINUS ||
                          c == CH_HASH))
                    begin
                        add_span(s, p, pgnlex_pkg::CL_MOVE);
                        s = p;
                        st = LX_NORMAL;
                        again = 1'b1;
                    end
                end
                LX_NUMBER:
                begin
                    if (!is_digit(c))
                    begin
                        add_span(s, p, pgnlex_pkg::CL_NUMBER);
                        s = p;
                        st = LX_NORMAL;
                        again = 1'b1;
                    end
                end
                LX_TAG:
                begin
                    if (c == CH_QUOTE)
                    begin
                        s = p;
                        st = LX_STRING;
                    end
                    else if (c == CH_RBRACK)
                    begin
                        add_span(s, p, pgnlex_pkg::CL_NONE);
                        add_span(p, p + 1, pgnlex_pkg::CL_PUNCT);
                        s = p + 1;
                        st = LX_NORMAL;
                    end
                    else if (c == CH_UNDER || is_letter(c))
                    begin
                        s = p;
                        st = LX_IDENT;
                    end
                end
                default:
                begin
                    st = LX_NORMAL;
                    if (c == CH_LBRACK)
                    begin
                        add_span(p, p + 1, pgnlex_pkg::CL_PUNCT);
                        s = p + 1;
                        st = LX_TAG;
                    end
                    else if (c == CH_DOLLAR || c == CH_DOT || c == CH_RBRACK ||
                             c == CH_LPAREN || c == CH_RPAREN || c == CH_BANG ||
                             c == CH_QMARK || c == CH_MINUS || c == CH_SLASH || c == CH_STAR)
                    begin
                        add_span(p, p + 1, pgnlex_pkg::CL_PUNCT);
                        s = p + 1;
                    end
                    else if (is_digit(c))
                    begin
                        s = p;
                        st = LX_NUMBER;
                    end
                    else if (c == CH_LBRACE)
                    begin
                        s = p;
                        st = LX_BRACE_CMT;
                    end
                    else if (c == CH_SEMI || c == CH_PERCENT)
                    begin
                        s = p;
                        st = LX_LINE_CMT;
                    end
                    else if (is_letter(c))
                    begin
                        s = p;
                        st = LX_MOVE;
                    end
                end
            endcase
        end
        next_pos = p + 1;
        if (b.line_last)
        begin
            case (st)
                LX_STRING, LX_STR_ESC:     fcls = pgnlex_pkg::CL_STRING;
                LX_LINE_CMT, LX_BRACE_CMT: fcls = pgnlex_pkg::CL_COMMENT;
                LX_MOVE:                   fcls = pgnlex_pkg::CL_MOVE;
                LX_NUMBER:                 fcls = pgnlex_pkg::CL_NUMBER;
                LX_IDENT:                  fcls = pgnlex_pkg::CL_IDENT;
                default:                   fcls = pgnlex_pkg::CL_NONE;
            endcase
            add_span(s, next_pos, fcls);
            next_pos = 0;
            s = 0;
        end
        lx_state = st;
        open_start = s;
        for (int i = 0; i < step_n; i++)
        begin
            step_spans[i].last_result = (i == step_n - 1);
            pending_spans.push_back(step_spans[i]);
        end
    endtask

    // sender
    always @(posedge clk)
    begin
        if (char_valid && !char_stall)
            lex_char(char_beat);
        if (!rst_n)
            char_valid <= 1'b0;
        else if (!char_valid || !char_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                char_valid <= 1'b0;
            end
            else if (char_q.size() > 0)
            begin
                char_beat <= char_q.pop_front();
                char_valid <= 1'b1;
                if (run_left > 0)
                    run_left--;
                else
                begin
                    run_left = $urandom_range(0, 24);
                    gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end
            end
            else
                char_valid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        pgnlex_pkg::span_beat_t exp_span;
        if (!rst_n)
            span_stall <= 1'b0;
        else
        begin
            if (stall_left > 0)
                stall_left--;
            else
            begin
                stall_left = $urandom_range(0, 6);
                span_stall <= ($urandom_range(1, 100) <= stall_pct);
            end
            if (span_valid && !span_stall)
            begin
                if (pending_spans.size() == 0)
                begin
                    errors++;
                    $display({"%0t unexpected span: expected none, ",
                              "got start=%0d len=%0d class=%0d last=%0b"},
                             $time, span_beat.span_start, span_beat.span_length,
                             span_beat.span_class, span_beat.last_result);
                end
                else
                begin
                    exp_span = pending_spans.pop_front();
                    if (span_beat.span_start !== exp_span.span_start ||
                        span_beat.span_length !== exp_span.span_length ||
                        span_beat.span_class !== exp_span.span_class ||
                        span_beat.last_result !== exp_span.last_result)
                    begin
                        errors++;
                        $display({"%0t span mismatch: expected start=%0d len=%0d ",
                                  "class=%0d last=%0b, got start=%0d len=%0d ",
                                  "class=%0d last=%0b"},
                                 $time, exp_span.span_start, exp_span.span_length,
                                 exp_span.span_class, exp_span.last_result,
                                 span_beat.span_start, span_beat.span_length,
                                 span_beat.span_class, span_beat.last_result);
                    end
                end
            end
        end
    end

    function automatic logic [15:0] rnd_letter();
        if ($urandom_range(0, 1) == 0)
            return CH_LA + 16'($urandom_range(0, 25));
        return CH_UA + 16'($urandom_range(0, 25));
    endfunction

    function automatic logic [15:0] rnd_digit();
        return CH_ZERO + 16'($urandom_range(0, 9));
    endfunction

    function automatic logic [15:0] rnd_text();
        if ($urandom_range(0, 11) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(32, 126));
    endfunction

    function automatic logic [15:0] rnd_punct();
        case ($urandom_range(0, 13))
            0:       return CH_DOLLAR;
            1:       return CH_DOT;
            2:       return CH_RBRACK;
            3:       return CH_LPAREN;
            4:       return CH_RPAREN;
            5:       return CH_BANG;
            6:       return CH_QMARK;
            7:       return CH_MINUS;
            8:       return CH_SLASH;
            9:       return CH_STAR;
            10:      return CH_PLUS;
            11:      return CH_HASH;
            12:      return CH_UNDER;
            default: return CH_BSLASH;
        endcase
    endfunction

    task automatic add_text(input string t);
        for (int i = 0; i < t.len(); i++)
            line_buf.push_back(16'(t[i]));
    endtask

    task automatic flush_line();
        pgnlex_pkg::char_beat_t b;
        if (line_buf.size() == 0)
            line_buf.push_back(CH_SPACE);
        foreach (line_buf[i])
        begin
            b.char_code = line_buf[i];
            b.line_last = (i == line_buf.size() - 1);
            char_q.push_back(b);
        end
        sent += line_buf.size();
        line_buf.delete();
    endtask

    // mostly well-formed PGN tokens, some left open or mixed with noise
    task automatic gen_tokens(input int ntok);
        logic [15:0] ch;
        for (int t = 0; t < ntok; t++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    line_buf.push_back(CH_LBRACK);
                    line_buf.push_back($urandom_range(0, 3) == 0 ? CH_UNDER : rnd_letter());
                    repeat ($urandom_range(0, 6))
                    begin
                        case ($urandom_range(0, 3))
                            0:       line_buf.push_back(rnd_digit());
                            1:       line_buf.push_back(CH_UNDER);
                            default: line_buf.push_back(rnd_letter());
                        endcase
                    end
                    line_buf.push_back(CH_SPACE);
                    line_buf.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 8))
                    begin
                        if ($urandom_range(0, 5) == 0)
                            line_buf.push_back(CH_BSLASH);
                        line_buf.push_back(rnd_text());
                    end
                    if ($urandom_range(0, 7) != 0)
                        line_buf.push_back(CH_QUOTE);
                    if ($urandom_range(0, 7) != 0)
                        line_buf.push_back(CH_RBRACK);
                end
                2:
                begin
                    repeat ($urandom_range(1, 3))
                        line_buf.push_back(rnd_digit());
                    line_buf.push_back(CH_DOT);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        line_buf.push_back(CH_DOT);
                        line_buf.push_back(CH_DOT);
                    end
                end
                3, 4:
                begin
                    line_buf.push_back(rnd_letter());
                    repeat ($urandom_range(1, 4))
                        line_buf.push_back($urandom_range(0, 1) ? rnd_digit() : rnd_letter());
                    case ($urandom_range(0, 5))
                        0: line_buf.push_back(CH_PLUS);
                        1: line_buf.push_back(CH_HASH);
                        2: line_buf.push_back(CH_MINUS);
                        default: ;
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        line_buf.push_back($urandom_range(0, 1) ? CH_BANG : CH_QMARK);
                end
                5:
                begin
                    line_buf.push_back(CH_LBRACE);
                    repeat ($urandom_range(0, 10))
                    begin
                        ch = rnd_text();
                        line_buf.push_back(ch == CH_RBRACE ? CH_SPACE : ch);
                    end
                    if ($urandom_range(0, 5) != 0)
                        line_buf.push_back(CH_RBRACE);
                end
                6:
                begin
                    line_buf.push_back($urandom_range(0, 1) ? CH_SEMI : CH_PERCENT);
                    repeat ($urandom_range(0, 8))
                        line_buf.push_back(rnd_text());
                    case ($urandom_range(0, 2))
                        0: line_buf.push_back(CH_CR);
                        1: line_buf.push_back(CH_LF);
                        default: ;
                    endcase
                end
                7:
                    line_buf.push_back(rnd_punct());
                8:
                    repeat ($urandom_range(1, 3))
                        line_buf.push_back(16'($urandom_range(0, 65535)));
                default:
                begin
                    line_buf.push_back(rnd_digit());
                    line_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_SLASH);
                    line_buf.push_back(rnd_digit());
                end
            endcase
            if ($urandom_range(0, 9) < 7)
                line_buf.push_back(CH_SPACE);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (char_q.size() != 0 || char_valid || pending_spans.size() != 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // escaped quote in a tag string
        add_text("[ \"\\\"\"]");
        flush_line();
        // identifier, then tag text closed by the bracket
        add_text("[_x9 *]");
        flush_line();
        // number, move, punctuation, brace comment left open at line end
        add_text("12.Nf3!{");
        flush_line();
        // comment carried over, line comment ended by CR, code unit extremes
        add_text("};");
        line_buf.push_back(16'h0000);
        line_buf.push_back(CH_CR);
        line_buf.push_back(16'hFFFF);
        flush_line();
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    gap_max = 4;
                    stall_pct = 30;
                end
                1:
                begin
                    gap_max = 0;
                    stall_pct = 0;
                end
                default:
                begin
                    gap_max = 8;
                    stall_pct = 60;
                end
            endcase
            sent = 0;
            while (sent < 130)
            begin
                gen_tokens($urandom_range(1, 8));
                flush_line();
            end
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
